>>> hw/rtl/rrwa_pkg.sv
// Package for the round-robin worker assigner.
// Holds the transaction payload types, the cell chain types and the code constants.
// Depends on nothing; every other file of the block imports it.
package rrwa_pkg;

   localparam int unsigned MaxWorkers = 16;
   localparam int unsigned SlotWidth  = 4;
   localparam int unsigned CountWidth = 5;
   localparam int unsigned OrderWidth = 32;
   localparam int unsigned TaskWidth  = 32;

   localparam logic [CountWidth-1:0] MaxActive = CountWidth'(MaxWorkers);

   typedef enum logic [1:0] {
      OP_ASSIGN     = 2'd0,
      OP_COMPLETE   = 2'd1,
      OP_SET_STATUS = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_AVAILABLE      = 2'd0,
      ST_BUSY           = 2'd1,
      ST_CHARGING       = 2'd2,
      ST_OUT_OF_SERVICE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      RC_DONE           = 3'd0,
      RC_NO_WORKERS     = 3'd1,
      RC_NONE_AVAILABLE = 3'd2,
      RC_NOT_REGISTERED = 3'd3,
      RC_NOT_BUSY       = 3'd4
   } result_type;

   typedef struct packed {
      logic [1:0]            operation;
      logic [OrderWidth-1:0] order_id;
      logic [SlotWidth-1:0]  worker_slot;
      logic [1:0]            new_status;
   } req_type;

   typedef struct packed {
      logic [2:0]            result_code;
      logic [SlotWidth-1:0]  served_slot;
      logic [OrderWidth-1:0] served_order;
      logic [TaskWidth-1:0]  served_task_count;
      logic [SlotWidth-1:0]  last_assigned_slot;
      logic                  last_assigned_valid;
   } rsp_type;

   typedef struct packed {
      logic high_found;
      logic low_found;
   } search_chain_type;

   typedef struct packed {
      logic [SlotWidth-1:0]  slot;
      logic [1:0]            status;
      logic [OrderWidth-1:0] order;
      logic [TaskWidth-1:0]  tasks;
   } read_chain_type;

endpackage

>>> hw/rtl/rrwa_cell.sv
// One worker slot of the assigner: status, current order and task count.
// Passes the round-robin search carry and the read bus on to its neighbor.
// Depends on rrwa_pkg.
module rrwa_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [rrwa_pkg::SlotWidth-1:0]       slot_index,
   input  logic [rrwa_pkg::CountWidth-1:0]      active_n,
   input  logic [rrwa_pkg::SlotWidth-1:0]       ptr_start,
   input  logic                                 any_high,
   input  logic                                 exec,
   input  rrwa_pkg::req_type                    req,
   input  logic                                 clear_cell,
   input  rrwa_pkg::search_chain_type           search_in,
   output rrwa_pkg::search_chain_type           search_out,
   input  rrwa_pkg::read_chain_type             read_in,
   output rrwa_pkg::read_chain_type             read_out,
   output logic                                 grant,
   output logic [1:0]                           status_out
);
   import rrwa_pkg::*;

   status_type             status_ff, status_in;
   logic [OrderWidth-1:0]  order_ff, order_in;
   logic [TaskWidth-1:0]   tasks_ff, tasks_in;
   logic                   registered, avail, high_req, pick_high, pick_low;
   logic                   is_assign, target;

   assign registered = {1'b0, slot_index} < active_n;
   assign avail      = registered && (status_ff == ST_AVAILABLE);
   assign high_req   = avail && (slot_index >= ptr_start);
   assign pick_high  = high_req && !search_in.high_found;
   assign pick_low   = avail && !search_in.low_found;
   assign is_assign  = (req.operation == OP_ASSIGN);
   assign grant      = is_assign && (any_high ? pick_high : pick_low);
   assign target     = is_assign ? grant : (req.worker_slot == slot_index);

   assign search_out.high_found = search_in.high_found | high_req;
   assign search_out.low_found  = search_in.low_found | avail;

   assign read_out.slot   = read_in.slot | (target ? slot_index : '0);
   assign read_out.status = read_in.status | (target ? 2'(status_ff) : 2'b00);
   assign read_out.order  = read_in.order | (target ? order_ff : '0);
   assign read_out.tasks  = read_in.tasks | (target ? tasks_ff : '0);

   assign status_out = 2'(status_ff);

   always_comb begin
      status_in = status_ff;
      order_in  = order_ff;
      tasks_in  = tasks_ff;
      if (clear_cell) begin
         status_in = ST_AVAILABLE;
         order_in  = '0;
         tasks_in  = '0;
      end else if (exec && target && registered) begin
         case (op_type'(req.operation))
            OP_ASSIGN: begin
               status_in = ST_BUSY;
               order_in  = req.order_id;
               tasks_in  = (tasks_ff == '1) ? tasks_ff : tasks_ff + TaskWidth'(1);
            end
            OP_COMPLETE: begin
               if (status_ff == ST_BUSY) begin
                  status_in = ST_AVAILABLE;
                  order_in  = '0;
               end
            end
            OP_SET_STATUS: begin
               status_in = status_type'(req.new_status);
               if (status_type'(req.new_status) == ST_AVAILABLE) begin
                  order_in = '0;
               end
            end
            default: begin
               status_in = status_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_AVAILABLE;
      end else begin
         status_ff <= status_in;
      end
      order_ff <= order_in;
      tasks_ff <= tasks_in;
   end

endmodule

>>> hw/rtl/round_robin_worker_assigner.sv
// Top level of the round-robin worker assigner: a chain of worker slot cells,
// the rotating pointer, the last-assignment record and the response register.
// Depends on rrwa_pkg and rrwa_cell.
//
// Requests arrive on the req_ channel (valid/ready) and each one produces exactly
// one response transaction on the rsp_ channel. A request is executed in the cycle
// it is accepted: the round-robin search ripples through the cell chain, the
// chosen or addressed cell updates, and the response is registered. A new request
// can be taken every cycle unless the response stalls; the speed is set by the
// search and read ripple through the sixteen cells.
// The response register holds its transaction while rsp_ready is low; req_ready
// then stays low, so a new request is taken in the same cycle the waiting response
// leaves. csr_write_enable writes the number of registered slots. Newly registered
// slots come up available with no order and zero tasks. The user must make
// writes only while idle; the block does not check it. Reset (synchronous, active
// high) sets the slot count to zero, the pointer and last-assignment record
// to zero, and empties the response register.
module round_robin_worker_assigner (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  rrwa_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output rrwa_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_enable,
   input  logic [rrwa_pkg::CountWidth-1:0]     csr_write_data
);
   import rrwa_pkg::*;

   logic [CountWidth-1:0]  active_n_ff, active_n_in, new_n;
   logic [SlotWidth-1:0]   ptr_ff, ptr_in, ptr_start, last_slot_ff, last_slot_in;
   logic                   last_valid_ff, last_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic                   exec, found, any_high;
   logic [CountWidth-1:0]  grant_next;
   logic [TaskWidth-1:0]   tasks_inc;
   logic [MaxWorkers-1:0]  grant_vec, clear_vec;
   logic [1:0]             status_vec [MaxWorkers];
   search_chain_type       search_chain [MaxWorkers+1];
   read_chain_type         read_chain [MaxWorkers+1];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign exec      = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign new_n     = (csr_write_data > MaxActive) ? MaxActive : csr_write_data;
   assign ptr_start = ({1'b0, ptr_ff} < active_n_ff) ? ptr_ff : '0;

   assign search_chain[0] = '0;
   assign read_chain[0]   = '0;
   assign any_high = search_chain[MaxWorkers].high_found;
   assign found    = search_chain[MaxWorkers].high_found | search_chain[MaxWorkers].low_found;

   for (genvar i = 0; i < MaxWorkers; i++) begin : g_cell
      assign clear_vec[i] = csr_write_enable && (CountWidth'(i) >= active_n_ff) &&
                            (CountWidth'(i) < new_n);
      rrwa_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .slot_index (SlotWidth'(i)),
         .active_n   (active_n_ff),
         .ptr_start  (ptr_start),
         .any_high   (any_high),
         .exec       (exec),
         .req        (req_data),
         .clear_cell (clear_vec[i]),
         .search_in  (search_chain[i]),
         .search_out (search_chain[i+1]),
         .read_in    (read_chain[i]),
         .read_out   (read_chain[i+1]),
         .grant      (grant_vec[i]),
         .status_out (status_vec[i])
      );
   end

   assign grant_next = {1'b0, read_chain[MaxWorkers].slot} + CountWidth'(1);
   assign tasks_inc  = (read_chain[MaxWorkers].tasks == '1) ? read_chain[MaxWorkers].tasks :
                       read_chain[MaxWorkers].tasks + TaskWidth'(1);

   always_comb begin
      active_n_in   = active_n_ff;
      ptr_in        = ptr_ff;
      last_slot_in  = last_slot_ff;
      last_valid_in = last_valid_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (exec) begin
         rsp_valid_in                  = 1'b1;
         rsp_data_in.result_code       = RC_DONE;
         rsp_data_in.served_slot       = '0;
         rsp_data_in.served_order      = '0;
         rsp_data_in.served_task_count = '0;
         case (op_type'(req_data.operation))
            OP_ASSIGN: begin
               if (active_n_ff == '0) begin
                  rsp_data_in.result_code = RC_NO_WORKERS;
               end else if (!found) begin
                  rsp_data_in.result_code = RC_NONE_AVAILABLE;
               end else begin
                  rsp_data_in.served_slot       = read_chain[MaxWorkers].slot;
                  rsp_data_in.served_order      = req_data.order_id;
                  rsp_data_in.served_task_count = tasks_inc;
                  last_slot_in  = read_chain[MaxWorkers].slot;
                  last_valid_in = 1'b1;
                  ptr_in = (grant_next == active_n_ff) ? '0 : grant_next[SlotWidth-1:0];
               end
            end
            OP_COMPLETE, OP_SET_STATUS: begin
               rsp_data_in.served_slot = req_data.worker_slot;
               if ({1'b0, req_data.worker_slot} >= active_n_ff) begin
                  rsp_data_in.result_code = RC_NOT_REGISTERED;
               end else begin
                  rsp_data_in.served_task_count = read_chain[MaxWorkers].tasks;
                  if (op_type'(req_data.operation) == OP_COMPLETE) begin
                     if (read_chain[MaxWorkers].status == ST_BUSY) begin
                        rsp_data_in.served_order = read_chain[MaxWorkers].order;
                     end else begin
                        rsp_data_in.result_code = RC_NOT_BUSY;
                     end
                  end
               end
            end
            default: begin
               rsp_data_in.result_code = RC_DONE;
            end
         endcase
         rsp_data_in.last_assigned_slot  = last_slot_in;
         rsp_data_in.last_assigned_valid = last_valid_in;
      end

      if (csr_write_enable) begin
         active_n_in = new_n;
         if ({1'b0, ptr_in} >= new_n) begin
            ptr_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_n_ff   <= '0;
         ptr_ff        <= '0;
         last_slot_ff  <= '0;
         last_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         active_n_ff   <= active_n_in;
         ptr_ff        <= ptr_in;
         last_slot_ff  <= last_slot_in;
         last_valid_ff <= last_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      $onehot0(grant_vec))
      else $error("More than one worker slot granted.");

   assert property (@(posedge clock) disable iff (reset)
      ptr_ff == '0 || {1'b0, ptr_ff} < active_n_ff)
      else $error("Rotate pointer outside the registered slots.");

   assert property (@(posedge clock) disable iff (reset)
      active_n_ff <= MaxActive)
      else $error("Registered slot count above the slot table size.");

   assert property (@(posedge clock) disable iff (reset)
      exec && req_data.operation == OP_ASSIGN && active_n_ff != '0 && found
      |=> status_vec[last_slot_ff] == ST_BUSY && last_valid_ff)
      else $error("Assigned worker slot is not busy after the assignment.");

   assert property (@(posedge clock) disable iff (reset)
      last_valid_ff |=> last_valid_ff)
      else $error("Last-assignment record lost its valid flag.");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for round_robin_worker_assigner: directed and random requests
// with a built-in model of the slot table, and random idling on both handshakes.
// Depends on rrwa_pkg and the round_robin_worker_assigner RTL.
module testbench;
   import rrwa_pkg::*;

   localparam logic [1:0] OpUnused = 2'd3;
   localparam int CycleLimit = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b1;
   rsp_type               rsp_data;
   logic                  csr_write_enable = 1'b0;
   logic [CountWidth-1:0] csr_write_data = '0;

   round_robin_worker_assigner dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model of the slot table.
   logic [CountWidth-1:0] registered_count = '0;
   status_type            slot_status [MaxWorkers];
   logic [OrderWidth-1:0] slot_order [MaxWorkers];
   logic [TaskWidth-1:0]  slot_tasks [MaxWorkers];
   logic [SlotWidth-1:0]  rr_pointer = '0;
   logic [SlotWidth-1:0]  last_slot = '0;
   logic                  last_valid = 1'b0;

   rsp_type outcomes_due[$];
   bit      idle_on = 1'b1;
   int      stall_left = 0;
   int      cycle_count = 0;
   int      mismatch_count = 0;
   int      request_count = 0;
   int      grant_count = 0;
   int      setting_count = 0;

   initial begin
      for (int i = 0; i < MaxWorkers; i++) begin
         slot_status[i] = ST_AVAILABLE;
         slot_order[i] = '0;
         slot_tasks[i] = '0;
      end
   end

   function automatic int unsigned active_slots();
      return (registered_count > MaxActive) ? MaxWorkers : int'(registered_count);
   endfunction

   function automatic void resize_table(input logic [CountWidth-1:0] value);
      int unsigned old_n;
      int unsigned new_n;
      old_n = active_slots();
      registered_count = value;
      new_n = active_slots();
      for (int unsigned i = old_n; i < new_n; i++) begin
         slot_status[i] = ST_AVAILABLE;
         slot_order[i] = '0;
         slot_tasks[i] = '0;
      end
      if (rr_pointer >= new_n) begin
         rr_pointer = '0;
      end
   endfunction

   function automatic rsp_type serve_request(input req_type r);
      rsp_type     o;
      int unsigned n;
      int unsigned p;
      bit          found;
      n = active_slots();
      o = '0;
      o.result_code = RC_DONE;
      found = 1'b0;
      case (r.operation)
         OP_ASSIGN: begin
            if (n == 0) begin
               o.result_code = RC_NO_WORKERS;
            end else begin
               p = (rr_pointer < n) ? int'(rr_pointer) : 0;
               for (int unsigned k = 0; k < n && !found; k++) begin
                  if (slot_status[p] == ST_AVAILABLE) begin
                     found = 1'b1;
                     slot_status[p] = ST_BUSY;
                     slot_order[p] = r.order_id;
                     if (slot_tasks[p] != '1) begin
                        slot_tasks[p] = slot_tasks[p] + 1;
                     end
                     last_slot = p[SlotWidth-1:0];
                     last_valid = 1'b1;
                     o.served_slot = p[SlotWidth-1:0];
                     o.served_order = r.order_id;
                     o.served_task_count = slot_tasks[p];
                     grant_count++;
                  end
                  p = (p + 1) % n;
               end
               if (found) begin
                  rr_pointer = p[SlotWidth-1:0];
               end else begin
                  o.result_code = RC_NONE_AVAILABLE;
               end
            end
         end
         OP_COMPLETE, OP_SET_STATUS: begin
            o.served_slot = r.worker_slot;
            if (r.worker_slot >= n) begin
               o.result_code = RC_NOT_REGISTERED;
            end else if (r.operation == OP_COMPLETE) begin
               if (slot_status[r.worker_slot] == ST_BUSY) begin
                  o.served_order = slot_order[r.worker_slot];
                  slot_status[r.worker_slot] = ST_AVAILABLE;
                  slot_order[r.worker_slot] = '0;
               end else begin
                  o.result_code = RC_NOT_BUSY;
               end
               o.served_task_count = slot_tasks[r.worker_slot];
            end else begin
               slot_status[r.worker_slot] = status_type'(r.new_status);
               if (r.new_status == ST_AVAILABLE) begin
                  slot_order[r.worker_slot] = '0;
               end
               o.served_task_count = slot_tasks[r.worker_slot];
            end
         end
         default: begin
         end
      endcase
      o.last_assigned_slot = last_slot;
      o.last_assigned_valid = last_valid;
      return o;
   endfunction

   function automatic req_type make_request(input logic [1:0] op,
                                            input logic [OrderWidth-1:0] order,
                                            input logic [SlotWidth-1:0] slot,
                                            input logic [1:0] status);
      req_type r;
      r.operation = op;
      r.order_id = order;
      r.worker_slot = slot;
      r.new_status = status;
      return r;
   endfunction

   function automatic req_type random_request();
      req_type     r;
      int unsigned pick;
      int unsigned n;
      n = active_slots();
      pick = $urandom_range(0, 99);
      r.operation = (pick < 40) ? OP_ASSIGN : (pick < 70) ? OP_COMPLETE :
                    (pick < 92) ? OP_SET_STATUS : OpUnused;
      r.order_id = ($urandom_range(0, 31) == 0) ? '0 : $urandom;
      if (n > 0 && $urandom_range(0, 9) != 0) begin
         r.worker_slot = SlotWidth'($urandom_range(0, n - 1));
      end else begin
         r.worker_slot = SlotWidth'($urandom_range(0, MaxWorkers - 1));
      end
      r.new_status = ($urandom_range(0, 2) == 0) ? ST_AVAILABLE : 2'($urandom_range(0, 3));
      return r;
   endfunction

   // Called and left at a falling edge; valid is low on return.
   task automatic send_request(input req_type r);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      do @(posedge clock); while (!req_ready);
      outcomes_due.push_back(serve_request(r));
      request_count++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_idle();
      while (outcomes_due.size() != 0) @(negedge clock);
   endtask

   task automatic write_worker_count(input logic [CountWidth-1:0] value);
      wait_idle();
      repeat (3) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_write_data = value;
      resize_table(value);
      setting_count++;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else begin
         rsp_ready = 1'b1;
         if (idle_on && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 18);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcomes_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: response with nothing outstanding: %h", $realtime, rsp_data);
            end
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_data.result_code !== want.result_code ||
                rsp_data.served_slot !== want.served_slot ||
                rsp_data.served_order !== want.served_order ||
                rsp_data.served_task_count !== want.served_task_count ||
                rsp_data.last_assigned_slot !== want.last_assigned_slot ||
                rsp_data.last_assigned_valid !== want.last_assigned_valid) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: expected code %0d slot %0d order %h tasks %h last %0d/%0b",
                           $realtime, want.result_code, want.served_slot, want.served_order,
                           want.served_task_count, want.last_assigned_slot,
                           want.last_assigned_valid);
                  $display("%0t:      got code %0d slot %0d order %h tasks %h last %0d/%0b",
                           $realtime, rsp_data.result_code, rsp_data.served_slot,
                           rsp_data.served_order, rsp_data.served_task_count,
                           rsp_data.last_assigned_slot, rsp_data.last_assigned_valid);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("round_robin_worker_assigner: mismatch");
         $finish;
      end
   end

   task automatic test_no_workers();
      write_worker_count(5'd0);
      send_request(make_request(OP_ASSIGN, 32'h0000_0001, 4'd0, ST_AVAILABLE));
      send_request(make_request(OP_COMPLETE, '0, 4'd0, ST_AVAILABLE));
      send_request(make_request(OP_SET_STATUS, '0, 4'd15, ST_OUT_OF_SERVICE));
      send_request(make_request(OpUnused, 32'hFFFF_FFFF, 4'd15, 2'd3));
   endtask

   task automatic test_single_worker();
      write_worker_count(5'd1);
      send_request(make_request(OP_ASSIGN, 32'hFFFF_FFFF, 4'd0, ST_AVAILABLE));
      send_request(make_request(OP_ASSIGN, 32'h1234_5678, 4'd0, ST_AVAILABLE));
      send_request(make_request(OP_COMPLETE, '0, 4'd0, ST_AVAILABLE));
      send_request(make_request(OP_COMPLETE, '0, 4'd0, ST_AVAILABLE));
      send_request(make_request(OP_SET_STATUS, '0, 4'd0, ST_CHARGING));
      send_request(make_request(OP_ASSIGN, 32'h0000_0002, 4'd0, ST_AVAILABLE));
      send_request(make_request(OP_SET_STATUS, '0, 4'd0, ST_AVAILABLE));
      send_request(make_request(OP_COMPLETE, '0, 4'd15, ST_AVAILABLE));
   endtask

   task automatic test_count_saturation();
      write_worker_count(5'd31);
      send_request(make_request(OP_ASSIGN, '0, 4'd0, ST_AVAILABLE));
      send_request(make_request(OP_SET_STATUS, '0, 4'd15, ST_BUSY));
      send_request(make_request(OP_ASSIGN, 32'h8000_0000, 4'd0, ST_AVAILABLE));
      send_request(make_request(OpUnused, '0, 4'd3, ST_AVAILABLE));
      send_request(make_request(OP_COMPLETE, '0, 4'd15, ST_AVAILABLE));
   endtask

   task automatic test_shrink_and_grow();
      write_worker_count(5'd2);
      send_request(make_request(OP_ASSIGN, 32'h0000_00AA, 4'd0, ST_AVAILABLE));
      send_request(make_request(OP_COMPLETE, '0, 4'd1, ST_AVAILABLE));
      send_request(make_request(OP_ASSIGN, 32'h0000_00BB, 4'd0, ST_AVAILABLE));
      write_worker_count(5'd16);
      send_request(make_request(OP_ASSIGN, 32'h0000_00CC, 4'd0, ST_AVAILABLE));
   endtask

   task automatic test_drain_pause();
      write_worker_count(5'd8);
      for (int i = 0; i < 40; i++) begin
         send_request(random_request());
         if (i % 10 == 9) begin
            wait_idle();
         end
      end
   endtask

   task automatic test_random_phases();
      logic [CountWidth-1:0] counts [4];
      counts = '{5'd16, 5'd31, 5'd1, 5'd0};
      for (int phase = 0; phase < 10; phase++) begin
         write_worker_count(phase < 4 ? counts[phase] : CountWidth'($urandom_range(0, 31)));
         repeat (100) send_request(random_request());
      end
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      write_worker_count(5'd16);
      repeat (150) send_request(random_request());
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset = 1'b0;
      test_no_workers();
      test_single_worker();
      test_count_saturation();
      test_shrink_and_grow();
      test_drain_pause();
      test_random_phases();
      test_steady_stream();
      wait_idle();
      repeat (10) @(posedge clock);
      $display("Sent %0d requests across %0d slot-count settings; %0d assignments granted.",
               request_count, setting_count, grant_count);
      if (mismatch_count == 0 && outcomes_due.size() == 0) begin
         $display("round_robin_worker_assigner: match");
      end else begin
         $display("round_robin_worker_assigner: mismatch");
      end
      $finish;
   end

endmodule
